// ===== sv/spectrum_bar_led_driver_unit_assert.svh =====
// Assertion macros for the spectrum bar LED driver checker.
// Both sample on i_clk and are disabled while i_rst_n is low.
`ifndef SPECTRUM_BAR_LED_DRIVER_UNIT_ASSERT_SVH
`define SPECTRUM_BAR_LED_DRIVER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle.
`define SBLD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the next cycle.
`define SBLD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sbld_pkg.sv =====
// ----------------------------------------------------------------------------
// sbld_pkg
// Types, constants and helper functions of the spectrum bar LED driver.
// ----------------------------------------------------------------------------
package sbld_pkg;

    // default geometry
    localparam int P_BANDS          = 7;
    localparam int P_LEDS_PER_BAND  = 8;
    localparam int P_HISTORY_FRAMES = 10;

    localparam int LVL_W    = 3;
    localparam int SUM_W    = 7;
    localparam int LIT_W    = 4;
    localparam int SIL_W    = 7;
    localparam int THR_W    = 7;
    localparam int LFSR_W   = 16;
    localparam int SAMPLE_W = 10;
    localparam int CFG_W    = 16;

    localparam logic [SIL_W-1:0]  C_IDLE_HOLD  = 7'd100;
    localparam logic [SIL_W-1:0]  C_SILENT_MAX = 7'd127;
    localparam logic [THR_W-1:0]  C_THR_RST    = 7'd5;
    localparam logic [LFSR_W-1:0] C_SEED_RST   = 16'd1;
    localparam logic [LFSR_W-1:0] C_LFSR_TAPS  = 16'hB400;

    // configuration register indexes
    localparam logic [0:0] C_REG_IDLE_THR = 1'b0;
    localparam logic [0:0] C_REG_SEED     = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPD,
        ST_CLOSE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [SAMPLE_W-1:0] band_sample;
        logic [2:0]          band_index;
    } t_in_item;

    typedef struct packed {
        logic [5:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       idle_mode;
        logic       last_pixel;
    } t_out_item;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    // control from the frame logic to the pixel generator
    typedef struct packed {
        logic              start;
        logic              idle;
        logic              seed_load;
        logic [LFSR_W-1:0] seed;
    } t_pix_ctrl;

    typedef struct packed {
        logic busy;
    } t_pix_stat;

    // right-shift Galois step
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] s;
        s = v >> 1;
        if (v[0]) begin
            s = s ^ C_LFSR_TAPS;
        end
        return s;
    endfunction

    // 256 = 1 mod 255, so fold the two bytes and correct once or twice
    function automatic logic [7:0] mod255(input logic [LFSR_W-1:0] v);
        logic [8:0] s;
        logic [8:0] r;
        s = 9'(v[15:8]) + 9'(v[7:0]);
        if (s >= 9'd510) begin
            r = 9'd0;
        end else if (s >= 9'd255) begin
            r = s - 9'd255;
        end else begin
            r = s;
        end
        return r[7:0];
    endfunction

    function automatic t_rgb band_colour(input logic [2:0] b);
        t_rgb c;
        case (b)
            3'd0:    c = '{8'd139, 8'd0,   8'd255};
            3'd1:    c = '{8'd255, 8'd0,   8'd0};
            3'd2:    c = '{8'd255, 8'd127, 8'd0};
            3'd3:    c = '{8'd255, 8'd255, 8'd0};
            3'd4:    c = '{8'd0,   8'd255, 8'd0};
            3'd5:    c = '{8'd0,   8'd255, 8'd255};
            3'd6:    c = '{8'd0,   8'd0,   8'd255};
            default: c = '{8'd75,  8'd0,   8'd130};
        endcase
        return c;
    endfunction

endpackage

// ===== sv/sbld_hist_ram.sv =====
// ----------------------------------------------------------------------------
// sbld_hist_ram
// Level history memory: one write and one registered read port, with a
// valid bit per entry so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module sbld_hist_ram #(
    parameter int DEPTH  = 70,
    parameter int ADDR_W = 7,
    parameter int DATA_W = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_vld;
    logic [DATA_W-1:0] r_rd_data;
    logic              r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== sv/sbld_pixel_gen.sv =====
// ----------------------------------------------------------------------------
// sbld_pixel_gen
// Walks the bars of one frame in serpentine order into an output register,
// one pixel per cycle unless the output stalls; owns the idle colour LFSR.
// ----------------------------------------------------------------------------
module sbld_pixel_gen #(
    parameter int BANDS         = 7,
    parameter int LEDS_PER_BAND = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sbld_pkg::t_pix_ctrl    i_ctrl,
    output sbld_pkg::t_pix_stat    o_stat,
    input  logic [sbld_pkg::LIT_W-1:0] i_lit [BANDS],
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output sbld_pkg::t_out_item    o_out_data
);

    import sbld_pkg::*;

    localparam int BAND_W = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int PIX_W  = (LEDS_PER_BAND > 1) ? $clog2(LEDS_PER_BAND) : 1;

    logic              r_busy;
    logic              r_idle;
    logic [BAND_W-1:0] r_band;
    logic [PIX_W-1:0]  r_pix;
    logic [LFSR_W-1:0] r_lfsr;
    logic              r_out_vld;
    t_out_item         r_out;

    logic              w_load;
    logic              w_last;
    logic [LFSR_W-1:0] w_v1, w_v2, w_v3;
    logic [5:0]        w_base;
    logic [5:0]        w_pos;
    logic              w_on;
    t_rgb              w_col;

    assign w_load = r_busy && (!r_out_vld || !i_out_stall);
    assign w_last = (r_band == BAND_W'(BANDS - 1)) && (r_pix == PIX_W'(LEDS_PER_BAND - 1));

    assign w_v1 = lfsr_step(r_lfsr);
    assign w_v2 = lfsr_step(w_v1);
    assign w_v3 = lfsr_step(w_v2);

    // odd bands run up the chain, even bands run down
    assign w_base = 6'(int'(r_band) * LEDS_PER_BAND);
    assign w_pos  = r_band[0] ? (w_base + 6'(r_pix))
                              : (w_base + 6'(LEDS_PER_BAND - 1) - 6'(r_pix));
    assign w_on   = LIT_W'(r_pix) < i_lit[r_band];
    assign w_col  = band_colour(3'(r_band));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_idle    <= 1'b0;
            r_band    <= '0;
            r_pix     <= '0;
            r_lfsr    <= C_SEED_RST;
            r_out_vld <= 1'b0;
        end else begin
            if (i_ctrl.seed_load) begin
                r_lfsr <= (i_ctrl.seed == '0) ? LFSR_W'(1) : i_ctrl.seed;
            end
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_idle <= i_ctrl.idle;
                r_band <= '0;
                r_pix  <= '0;
            end else if (w_load) begin
                if (r_idle) begin
                    r_lfsr <= w_v3;
                end
                if (w_last) begin
                    r_busy <= 1'b0;
                end else if (r_pix == PIX_W'(LEDS_PER_BAND - 1)) begin
                    r_pix  <= '0;
                    r_band <= r_band + BAND_W'(1);
                end else begin
                    r_pix <= r_pix + PIX_W'(1);
                end
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.pixel_index <= w_pos;
            r_out.idle_mode   <= r_idle;
            r_out.last_pixel  <= w_last;
            if (r_idle) begin
                r_out.red   <= mod255(w_v1);
                r_out.green <= mod255(w_v2);
                r_out.blue  <= mod255(w_v3);
            end else if (w_on) begin
                r_out.red   <= w_col.r;
                r_out.green <= w_col.g;
                r_out.blue  <= w_col.b;
            end else begin
                r_out.red   <= 8'd0;
                r_out.green <= 8'd0;
                r_out.blue  <= 8'd0;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== sv/spectrum_bar_led_driver_unit.sv =====
// ----------------------------------------------------------------------------
// spectrum_bar_led_driver_unit
// Audio spectrum bar graph driver: band samples in, LED pixels out.
// ----------------------------------------------------------------------------
// Input channel: one request per band sample (i_in_valid / o_in_stall).
// Send bands 0 .. BANDS-1 in order; the last band closes a frame. A band
// index at or above BANDS is taken and dropped.
// Each sample first reads the level history memory, then writes back the
// new level and updates the band sum. A frame close adds a state for the
// silence decision, then BANDS*LEDS_PER_BAND pixel requests (56 by
// default) leave at one per cycle while the receiver does not stall; the
// first is valid once the pixel generator has registered its busy flag and
// then the pixel in its output register. The input stalls while a sample
// is updated and while a frame is closed and drawn, and opens again in the
// cycle after the last pixel enters the output register.
// Output channel (o_out_valid / i_out_stall): a stall holds the pixel in
// the output register and pauses the pixel walk.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx at once
// (0: idle threshold, 1: LFSR seed, which is loaded straight into the LFSR).
// Reset clears the history (per entry valid bits), the sums, the silent
// frame count and the slot, and loads threshold 5 and seed 1.
// ----------------------------------------------------------------------------
module spectrum_bar_led_driver_unit #(
    parameter int BANDS          = sbld_pkg::P_BANDS,
    parameter int LEDS_PER_BAND  = sbld_pkg::P_LEDS_PER_BAND,
    parameter int HISTORY_FRAMES = sbld_pkg::P_HISTORY_FRAMES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  sbld_pkg::t_in_item         i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output sbld_pkg::t_out_item        o_out_data,
    input  logic                       i_cfg_we,
    input  logic [0:0]                 i_cfg_idx,
    input  logic [sbld_pkg::CFG_W-1:0] i_cfg_data
);

    import sbld_pkg::*;

    localparam int DEPTH  = HISTORY_FRAMES * BANDS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W = (HISTORY_FRAMES > 1) ? $clog2(HISTORY_FRAMES) : 1;
    localparam int BAND_W = (BANDS > 1) ? $clog2(BANDS) : 1;

    t_state             r_state, n_state;
    logic [THR_W-1:0]   r_thr;
    logic [SLOT_W-1:0]  r_slot;
    logic [SIL_W-1:0]   r_silent;
    logic [SAMPLE_W-1:0] r_sample;
    logic [BAND_W-1:0]  r_band;
    logic [ADDR_W-1:0]  r_addr;
    logic [SUM_W-1:0]   r_sum [BANDS];
    logic [LIT_W-1:0]   r_lit [BANDS];

    logic               w_accept;
    logic               w_band_ok;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic [LVL_W-1:0]   w_old_lvl;
    logic [13:0]        w_prod;
    logic [13:0]        w_ceil_num;
    logic [LVL_W-1:0]   w_lvl;
    logic [LIT_W-1:0]   w_q0;
    logic [LIT_W-1:0]   w_lit;
    logic               w_active;
    logic [SIL_W-1:0]   w_inc;
    logic               w_idle;
    t_pix_ctrl          w_pix_ctrl;
    t_pix_stat          w_pix_stat;

    assign w_band_ok = {1'b0, i_in_data.band_index} < 4'(BANDS);
    assign w_accept  = i_in_valid && (r_state == ST_IDLE);
    assign w_rd_addr = ADDR_W'(int'(r_slot) * BANDS + int'(i_in_data.band_index));

    // level = floor(s*L/1024); lit = ceil(s*L/1023), where the quotient of
    // the numerator by 1024 is low by at most one
    assign w_prod     = 14'(r_sample) * 14'(LEDS_PER_BAND);
    assign w_lvl      = LVL_W'(w_prod >> 10);
    assign w_ceil_num = w_prod + 14'd1022;
    assign w_q0       = LIT_W'(w_ceil_num >> 10);
    assign w_lit      = w_q0 + LIT_W'((11'(w_ceil_num[9:0]) + 11'(w_q0)) >= 11'd1023);

    always_comb begin
        w_active = 1'b0;
        for (int b = 0; b < BANDS; b++) begin
            if (r_sum[b] >= SUM_W'(HISTORY_FRAMES)) begin
                w_active = 1'b1;
            end
        end
    end

    assign w_inc  = (r_silent == C_SILENT_MAX) ? r_silent : r_silent + SIL_W'(1);
    assign w_idle = !w_active && (w_inc > r_thr);

    sbld_hist_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (LVL_W)
    ) u_hist_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept && w_band_ok),
        .i_rd_addr (w_rd_addr),
        .i_wr_en   (r_state == ST_UPD),
        .i_wr_addr (r_addr),
        .i_wr_data (w_lvl),
        .o_rd_data (w_old_lvl)
    );

    always_comb begin
        w_pix_ctrl.start     = (r_state == ST_CLOSE);
        w_pix_ctrl.idle      = w_idle;
        w_pix_ctrl.seed_load = i_cfg_we && (i_cfg_idx == C_REG_SEED);
        w_pix_ctrl.seed      = i_cfg_data;
    end

    sbld_pixel_gen #(
        .BANDS         (BANDS),
        .LEDS_PER_BAND (LEDS_PER_BAND)
    ) u_pixel_gen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_pix_ctrl),
        .o_stat      (w_pix_stat),
        .i_lit       (r_lit),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && w_band_ok) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                n_state = (r_band == BAND_W'(BANDS - 1)) ? ST_CLOSE : ST_IDLE;
            end
            ST_CLOSE: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!w_pix_stat.busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= C_THR_RST;
            r_slot   <= '0;
            r_silent <= '0;
            for (int b = 0; b < BANDS; b++) begin
                r_sum[b] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    C_REG_IDLE_THR: r_thr <= THR_W'(i_cfg_data);
                    C_REG_SEED:     ;
                    default:        ;
                endcase
            end
            if (r_state == ST_UPD) begin
                r_sum[r_band] <= r_sum[r_band] - SUM_W'(w_old_lvl) + SUM_W'(w_lvl);
            end
            if (r_state == ST_CLOSE) begin
                r_slot <= (r_slot == SLOT_W'(HISTORY_FRAMES - 1)) ? '0
                                                                  : r_slot + SLOT_W'(1);
                if (w_active) begin
                    r_silent <= '0;
                end else if (w_idle) begin
                    r_silent <= C_IDLE_HOLD;
                end else begin
                    r_silent <= w_inc;
                end
            end
        end
    end

    // hold the request that is being worked on
    always_ff @(posedge i_clk) begin
        if (w_accept && w_band_ok) begin
            r_sample <= i_in_data.band_sample;
            r_band   <= BAND_W'(i_in_data.band_index);
            r_addr   <= w_rd_addr;
        end
        if (r_state == ST_UPD) begin
            r_lit[r_band] <= w_lit;
        end
    end

endmodule

// ===== sv/sbld_checker.sv =====
// ----------------------------------------------------------------------------
// sbld_checker
// Port level checks of the spectrum bar LED driver, bound to the top level.
// ----------------------------------------------------------------------------
`include "spectrum_bar_led_driver_unit_assert.svh"

module sbld_checker #(
    parameter int BANDS         = sbld_pkg::P_BANDS,
    parameter int LEDS_PER_BAND = sbld_pkg::P_LEDS_PER_BAND
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input sbld_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input sbld_pkg::t_out_item o_out_data
);

    import sbld_pkg::*;

    // the last pixel of the last bar sits at the top or bottom of that bar
    localparam int LAST_POS = ((BANDS - 1) % 2 == 1) ? BANDS * LEDS_PER_BAND - 1
                                                     : (BANDS - 1) * LEDS_PER_BAND;

    `SBLD_ASSERT_NEXT(a_in_hold, i_in_valid && o_in_stall,
        i_in_valid && $stable(i_in_data), "stalled sample request changed")

    `SBLD_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_data), "stalled pixel request changed")

    `SBLD_ASSERT_NOW(a_no_accept_mid_frame, o_out_valid && !o_out_data.last_pixel,
        o_in_stall, "input open while a frame is still drawn")

    `SBLD_ASSERT_NEXT(a_frame_gapless, o_out_valid && !i_out_stall && !o_out_data.last_pixel,
        o_out_valid && (o_out_data.idle_mode == $past(o_out_data.idle_mode)),
        "gap or mode change inside a frame")

    `SBLD_ASSERT_NOW(a_last_pos, o_out_valid && o_out_data.last_pixel,
        o_out_data.pixel_index == 6'(LAST_POS), "last pixel at wrong chain position")

endmodule

bind spectrum_bar_led_driver_unit sbld_checker #(
    .BANDS         (BANDS),
    .LEDS_PER_BAND (LEDS_PER_BAND)
) u_sbld_checker (.*);
